// ===== rtl/cylinder_shell_point_filter_assert.svh =====
// Assertion macros for the cylinder shell point filter.
// Used by the top level; relies on nothing else.
`ifndef CYLINDER_SHELL_POINT_FILTER_ASSERT_SVH
`define CYLINDER_SHELL_POINT_FILTER_ASSERT_SVH

// same-cycle implication
`define CSF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csf: assertion failed");

// next-cycle implication
`define CSF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csf: assertion failed");

`endif

// ===== rtl/csf_pkg.sv =====
// Shared constants for the cylinder shell point filter.
// No dependencies.
package csf_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int REG_IDX_W       = 3;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_AXIS_PX  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_PY  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_PZ  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_DX  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_DY  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_AXIS_DZ  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_BAND_TOL = 3'd7;
endpackage

// ===== rtl/csf_if.sv =====
// Stream interfaces of the cylinder shell point filter: points in, results out.
// Depends on csf_pkg.
interface csf_point_if #(parameter int COORD_WIDTH = csf_pkg::COORD_WIDTH_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          last_in;

    modport source (output valid, point_x, point_y, point_z, last_in, input ready);
    modport sink   (input valid, point_x, point_y, point_z, last_in, output ready);
endinterface

interface csf_result_if #(parameter int COORD_WIDTH = csf_pkg::COORD_WIDTH_DEF);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic        [COORD_WIDTH-2:0] axis_distance;
    logic                          on_shell;
    logic                          last_out;

    modport source (output valid, out_x, out_y, out_z, axis_distance, on_shell, last_out,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, axis_distance, on_shell, last_out,
                    output ready);
endinterface

// ===== rtl/csf_mul.sv =====
// Two-stage unsigned multiplier built from four half-width partial products.
// Depends on csf_pkg.
module csf_mul #(
    parameter int AW = csf_pkg::COORD_WIDTH_DEF,
    parameter int BW = csf_pkg::COORD_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [AW-1:0]  i_a,
    input  logic [BW-1:0]  i_b,
    output logic [AW+BW-1:0] o_p
);
    localparam int AL = (AW + 1) / 2;
    localparam int AH = AW - AL;
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] r_ll;
    logic [AL+BH-1:0] r_lh;
    logic [AH+BL-1:0] r_hl;
    logic [AH+BH-1:0] r_hh;
    logic [PW-1:0]    r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[AL-1:0]  * i_b[BL-1:0];
            r_lh <= i_a[AL-1:0]  * i_b[BW-1:BL];
            r_hl <= i_a[AW-1:AL] * i_b[BL-1:0];
            r_hh <= i_a[AW-1:AL] * i_b[BW-1:BL];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= PW'(r_ll) + (PW'(r_lh) << BL) + (PW'(r_hl) << AL)
                 + (PW'(r_hh) << (AL + BL));
        end
    end

    assign o_p = r_p;
endmodule

// ===== rtl/csf_root.sv =====
// Pipelined floor(sqrt(sum / norm)): restoring divider, one quotient bit per
// stage, then a restoring square root, one root bit per stage. Depends on csf_pkg.
module csf_root #(
    parameter int RW = csf_pkg::COORD_WIDTH_DEF,
    parameter int NW = 2 * csf_pkg::COORD_WIDTH_DEF,
    parameter int SW = 4 * csf_pkg::COORD_WIDTH_DEF + 2,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [SW-1:0] i_sum,
    input  logic [NW-1:0] i_norm,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [RW-1:0] o_root,
    output logic          o_sat,
    output logic [TW-1:0] o_tag
);
    localparam int QB   = 2 * RW;
    localparam int SH   = SW - QB;
    localparam int LAST = QB + RW;

    logic          r_vld  [0:LAST];
    logic [TW-1:0] r_tag  [0:LAST];
    logic          r_sat  [0:LAST];
    logic [NW-1:0] r_drem [0:QB];
    // low dividend bits shift out at the top, quotient bits shift in at the bottom
    logic [QB-1:0] r_dlow [0:QB];
    logic [QB-1:0] r_sq    [1:RW-1];
    logic [RW:0]   r_srem  [1:RW-1];
    logic [RW-1:0] r_sroot [1:RW];
    logic [QB-1:0] w_qin   [0:RW-1];
    logic [RW:0]   w_remin [0:RW-1];
    logic [RW-1:0] w_rtin  [0:RW-1];

    // entry: quotient would not fit in QB bits -> saturate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0]  <= i_tag;
            r_sat[0]  <= (i_sum[SW-1:QB] >= SH'(i_norm));
            r_drem[0] <= i_sum[QB+NW-1:QB];
            r_dlow[0] <= i_sum[QB-1:0];
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic [NW:0] w_t;
        logic [NW:0] w_d;
        logic        w_ge;

        always_comb begin
            w_t  = {r_drem[k], r_dlow[k][QB-1]};
            w_d  = w_t - {1'b0, i_norm};
            w_ge = (w_t >= {1'b0, i_norm});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k+1]  <= r_tag[k];
                r_sat[k+1]  <= r_sat[k];
                r_drem[k+1] <= w_ge ? w_d[NW-1:0] : w_t[NW-1:0];
                r_dlow[k+1] <= {r_dlow[k][QB-2:0], w_ge};
            end
        end
    end

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        logic [RW+2:0] w_t;
        logic [RW+2:0] w_trial;
        logic [RW+2:0] w_d;
        logic          w_ge;

        if (j == 0) begin : g_first
            assign w_qin[j]   = r_dlow[QB];
            assign w_remin[j] = '0;
            assign w_rtin[j]  = '0;
        end else begin : g_next
            assign w_qin[j]   = r_sq[j];
            assign w_remin[j] = r_srem[j];
            assign w_rtin[j]  = r_sroot[j];
        end

        always_comb begin
            w_t     = {w_remin[j], w_qin[j][QB-1-2*j -: 2]};
            w_trial = {1'b0, w_rtin[j], 2'b01};
            w_d     = w_t - w_trial;
            w_ge    = (w_t >= w_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[QB+j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[QB+j+1] <= r_vld[QB+j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[QB+j+1] <= r_tag[QB+j];
                r_sat[QB+j+1] <= r_sat[QB+j];
                r_sroot[j+1]  <= {w_rtin[j][RW-2:0], w_ge};
            end
        end

        if (j < RW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sq[j+1]   <= w_qin[j];
                    r_srem[j+1] <= w_ge ? w_d[RW:0] : w_t[RW:0];
                end
            end
        end
    end

    assign o_valid = r_vld[LAST];
    assign o_root  = r_sroot[RW];
    assign o_sat   = r_sat[LAST];
    assign o_tag   = r_tag[LAST];
endmodule

// ===== rtl/cylinder_shell_point_filter.sv =====
// Top level of the cylinder shell point filter: config registers, cross
// product pipeline, root pipeline, output skid. Uses csf_pkg, csf_if, csf_mul, csf_root.
//
//   channel   dir  handshake            payload
//   i_pt      in   valid/ready          point_x, point_y, point_z, last_in
//   o_res     out  valid/ready          out_x/y/z, axis_distance, on_shell, last_out
//   i_cfg_*   in   write enable only    i_cfg_idx, i_cfg_data
//
// One point per cycle sustained while the output skid is not full. The divider
// produces one quotient bit per stage and the square root one root bit per stage.
// Synchronous active-low reset clears valid bits and config registers only.
// All stages advance together; a full skid register behind the output register
// freezes the pipe and drops i_pt.ready, so nothing is lost or repeated.
// The squared direction norm settles via r_md, u_nsq and r_norm after a config write.
`include "cylinder_shell_point_filter_assert.svh"

module cylinder_shell_point_filter #(
    parameter int COORD_WIDTH = csf_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [csf_pkg::REG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data,
    csf_point_if.sink                     i_pt,
    csf_result_if.source                  o_res
);
    localparam int W  = COORD_WIDTH;
    localparam int PW = 2 * W;       // |v|*|d| and |cross| width
    localparam int SW = 4 * W + 2;   // squared cross norm
    localparam logic [W-2:0] DMAX = {(W-1){1'b1}};
    // v and d operand for each of the six cross-product terms
    localparam int PV [0:5] = '{1, 2, 2, 0, 0, 1};
    localparam int PD [0:5] = '{2, 1, 0, 2, 1, 0};

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
        logic                last;
        logic                dzero;
    } t_tag;

    typedef struct packed {
        logic signed [W-1:0] x;
        logic signed [W-1:0] y;
        logic signed [W-1:0] z;
        logic [W-2:0]        axis_dist;
        logic                keep;
        logic                last;
    } t_res;

    localparam int TW = $bits(t_tag);

    // ---------------- configuration ----------------
    logic signed [W-1:0] r_axis_p [0:2];
    logic signed [W-1:0] r_axis_d [0:2];
    logic [W-2:0]        r_radius;
    logic [W-2:0]        r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_axis_p[i] <= '0;
                r_axis_d[i] <= '0;
            end
            r_radius <= '0;
            r_tol    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                csf_pkg::REG_AXIS_PX:  r_axis_p[0] <= i_cfg_data;
                csf_pkg::REG_AXIS_PY:  r_axis_p[1] <= i_cfg_data;
                csf_pkg::REG_AXIS_PZ:  r_axis_p[2] <= i_cfg_data;
                csf_pkg::REG_AXIS_DX:  r_axis_d[0] <= i_cfg_data;
                csf_pkg::REG_AXIS_DY:  r_axis_d[1] <= i_cfg_data;
                csf_pkg::REG_AXIS_DZ:  r_axis_d[2] <= i_cfg_data;
                csf_pkg::REG_RADIUS:   r_radius    <= i_cfg_data[W-2:0];
                csf_pkg::REG_BAND_TOL: r_tol       <= i_cfg_data[W-2:0];
            endcase
        end
    end

    // Direction magnitudes/signs and |d|^2 run free off the config registers.
    logic [W-1:0]  r_md [0:2];
    logic          r_sd [0:2];
    logic [PW-1:0] w_dsq [0:2];
    logic [PW-1:0] r_norm;
    logic          w_dzero;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_md[i] <= r_axis_d[i][W-1] ? W'(-r_axis_d[i]) : r_axis_d[i];
            r_sd[i] <= r_axis_d[i][W-1];
        end
        // fits: three squares of at most 2^(2W-2)
        r_norm <= w_dsq[0] + w_dsq[1] + w_dsq[2];
    end

    for (genvar i = 0; i < 3; i++) begin : g_nsq
        csf_mul #(.AW(W), .BW(W)) u_nsq (
            .i_clk (i_clk),
            .i_en  (1'b1),
            .i_a   (r_md[i]),
            .i_b   (r_md[i]),
            .o_p   (w_dsq[i])
        );
    end

    assign w_dzero = (r_axis_d[0] == '0) && (r_axis_d[1] == '0) && (r_axis_d[2] == '0);

    // ---------------- pipeline control ----------------
    logic w_en;
    logic r_out_vld;
    logic r_skid_vld;
    t_res r_out;
    t_res r_skid;

    assign w_en       = !r_skid_vld;
    assign i_pt.ready = w_en;

    // ---------------- stage 1: v = P - A ----------------
    logic                r1_vld;
    t_tag                r1_tag;
    logic signed [W:0]   r1_v [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_pt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_tag <= '{x: i_pt.point_x, y: i_pt.point_y, z: i_pt.point_z,
                        last: i_pt.last_in, dzero: w_dzero};
            r1_v[0] <= {i_pt.point_x[W-1], i_pt.point_x} - {r_axis_p[0][W-1], r_axis_p[0]};
            r1_v[1] <= {i_pt.point_y[W-1], i_pt.point_y} - {r_axis_p[1][W-1], r_axis_p[1]};
            r1_v[2] <= {i_pt.point_z[W-1], i_pt.point_z} - {r_axis_p[2][W-1], r_axis_p[2]};
        end
    end

    // ---------------- stage 2: |v| (fits W bits) ----------------
    logic          r2_vld;
    t_tag          r2_tag;
    logic [W-1:0]  r2_mv [0:2];
    logic          r2_sv [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_tag <= r1_tag;
            for (int i = 0; i < 3; i++) begin
                r2_mv[i] <= r1_v[i][W] ? W'(-r1_v[i]) : r1_v[i][W-1:0];
                r2_sv[i] <= r1_v[i][W];
            end
        end
    end

    // ---------------- stages 3-4: six |v_i|*|d_j| ----------------
    logic          r3_vld, r4_vld;
    t_tag          r3_tag, r4_tag;
    logic          r3_sg [0:5];
    logic          r4_sg [0:5];
    logic [PW-1:0] w_prod [0:5];

    for (genvar k = 0; k < 6; k++) begin : g_xmul
        csf_mul #(.AW(W), .BW(W)) u_xmul (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r2_mv[PV[k]]),
            .i_b   (r_md[PD[k]]),
            .o_p   (w_prod[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_tag <= r2_tag;
            r4_tag <= r3_tag;
            for (int k = 0; k < 6; k++) begin
                r3_sg[k] <= r2_sv[PV[k]] ^ r_sd[PD[k]];
                r4_sg[k] <= r3_sg[k];
            end
        end
    end

    // ---------------- stages 5-7: signed terms, cross, |cross| ----------------
    logic                 r5_vld, r6_vld, r7_vld;
    t_tag                 r5_tag, r6_tag, r7_tag;
    logic signed [PW:0]   r5_sp [0:5];
    logic signed [PW+1:0] r6_c  [0:2];
    logic [PW-1:0]        r7_ac [0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= r4_vld;
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_tag <= r4_tag;
            r6_tag <= r5_tag;
            r7_tag <= r6_tag;
            for (int k = 0; k < 6; k++) begin
                r5_sp[k] <= r4_sg[k] ? -$signed({1'b0, w_prod[k]}) : $signed({1'b0, w_prod[k]});
            end
            for (int m = 0; m < 3; m++) begin
                r6_c[m]  <= (PW+2)'(r5_sp[2*m]) - (PW+2)'(r5_sp[2*m+1]);
                // |cross| < 2^(2W), the top bits are sign only
                r7_ac[m] <= r6_c[m][PW+1] ? PW'(-r6_c[m]) : r6_c[m][PW-1:0];
            end
        end
    end

    // ---------------- stages 8-10: squares and their sum ----------------
    logic            r8_vld, r9_vld, r10_vld;
    t_tag            r8_tag, r9_tag, r10_tag;
    logic [2*PW-1:0] w_sq [0:2];
    logic [SW-1:0]   r10_sum;

    for (genvar m = 0; m < 3; m++) begin : g_sq
        csf_mul #(.AW(PW), .BW(PW)) u_sq (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (r7_ac[m]),
            .i_b   (r7_ac[m]),
            .o_p   (w_sq[m])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
        end else if (w_en) begin
            r8_vld  <= r7_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_tag  <= r7_tag;
            r9_tag  <= r8_tag;
            r10_tag <= r9_tag;
            r10_sum <= SW'(w_sq[0]) + SW'(w_sq[1]) + SW'(w_sq[2]);
        end
    end

    // ---------------- divide and square root ----------------
    logic          w_rt_vld;
    logic [W-1:0]  w_rt_root;
    logic          w_rt_sat;
    logic [TW-1:0] w_rt_tag;

    csf_root #(.RW(W), .NW(PW), .SW(SW), .TW(TW)) u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r10_vld),
        .i_sum   (r10_sum),
        .i_norm  (r_norm),
        .i_tag   (r10_tag),
        .o_valid (w_rt_vld),
        .o_root  (w_rt_root),
        .o_sat   (w_rt_sat),
        .o_tag   (w_rt_tag)
    );

    // ---------------- stages F1-F2: deviation from radius ----------------
    logic              r11_vld, r12_vld;
    t_tag              r11_tag, r12_tag;
    logic [W-1:0]      r11_dist, r12_dist;
    logic              r11_far, r12_far;   // distance >= 2^W
    logic signed [W:0] r11_diff;
    logic [W-1:0]      r12_adiff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_vld <= 1'b0;
            r12_vld <= 1'b0;
        end else if (w_en) begin
            r11_vld <= w_rt_vld;
            r12_vld <= r11_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_tag   <= t_tag'(w_rt_tag);
            r11_dist  <= w_rt_root;
            r11_far   <= w_rt_sat;
            r11_diff  <= $signed({1'b0, w_rt_root}) - $signed({2'b00, r_radius});
            r12_tag   <= r11_tag;
            r12_dist  <= r11_dist;
            r12_far   <= r11_far;
            r12_adiff <= r11_diff[W] ? W'(-r11_diff) : r11_diff[W-1:0];
        end
    end

    // ---------------- final decision and output skid ----------------
    t_res w_fin;

    always_comb begin
        w_fin.x    = r12_tag.x;
        w_fin.y    = r12_tag.y;
        w_fin.z    = r12_tag.z;
        w_fin.last = r12_tag.last;
        w_fin.keep = !r12_tag.dzero && !r12_far && (r12_adiff < {1'b0, r_tol});
        priority if (r12_tag.dzero) begin
            w_fin.axis_dist = '0;
        end else if (r12_far || r12_dist[W-1]) begin
            w_fin.axis_dist = DMAX;
        end else begin
            w_fin.axis_dist = r12_dist[W-2:0];
        end
    end

    logic w_take;
    logic w_new;

    assign w_take = r_out_vld && o_res.ready;
    assign w_new  = w_en && r12_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_new) begin
            if (r_out_vld && !w_take) begin
                r_skid_vld <= 1'b1;
            end else begin
                r_out_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_new) begin
            if (r_out_vld && !w_take) begin
                r_skid <= w_fin;
            end else begin
                r_out <= w_fin;
            end
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.out_x         = r_out.x;
    assign o_res.out_y         = r_out.y;
    assign o_res.out_z         = r_out.z;
    assign o_res.axis_distance = r_out.axis_dist;
    assign o_res.on_shell      = r_out.keep;
    assign o_res.last_out      = r_out.last;

    // ---------------- assertions ----------------
    // skid only ever holds the second of two waiting results
    `CSF_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld)
    // skid fills only when the output register was stuck
    `CSF_ASSERT_NOW(a_skid_fill_on_stall, i_clk, i_rst_n, $rose(r_skid_vld),
                    $past(r_out_vld && !o_res.ready))
    // a frozen pipe keeps its front stage
    `CSF_ASSERT_NEXT(a_freeze_holds_front, i_clk, i_rst_n, !w_en, $stable(r1_vld))
    // a zero axis never marks a point as kept
    `CSF_ASSERT_NOW(a_zero_axis_no_keep, i_clk, i_rst_n, r12_vld && r12_tag.dzero,
                    !w_fin.keep)
endmodule
